[sv/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package pps_pkg;

  // Default table size and fixed field widths
  localparam int unsigned TaskSlotsDef = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned ArrW         = 16;
  localparam int unsigned BurstW       = 16;
  localparam int unsigned PrioW        = 8;
  localparam int unsigned SlotOutW     = 4;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DRAIN  = 8'b0000_1000,
    S_RUN    = 8'b0001_0000,
    S_FIN    = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_REPORT = 8'b1000_0000
  } state_e;

  // One task table entry
  typedef struct packed {
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] remaining;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // item taken: latch operands, clear result, arm scan
    logic load;       // store the latched task
    logic scan_step;  // read the next slot of the round-robin sweep
    logic run;        // run the chosen task for one unit, advance time
    logic finish;     // compute turnaround and waiting of the finished task
    logic clear;      // empty the table and restart time
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;    // this read is the last slot of the sweep
    logic will_finish;  // the chosen task has one unit left
  } sts_t;

endpackage

`default_nettype wire

[sv/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler.
// Instantiates pps_ctrl and pps_dp; uses pps_pkg for types and defaults.
//
// Usage:
//   An item is taken at a rising clock edge with start high and busy low.
//   operation_i selects load task, tick, clear, or no change. Exactly one
//   result follows each item: strobe_o is high for one cycle and all result
//   ports are valid in that cycle. The receiver cannot stall; the result
//   must be taken in its strobe cycle. busy stays high until the strobe
//   cycle ends, so the next item can be offered right after.
// Each item passes through its controller states in order:
//   load: LOAD, REPORT; clear: CLEAR, REPORT; no-change: REPORT;
//   tick: SCAN over every slot, DRAIN, RUN, then FIN when the task
//   finishes, then REPORT. The tick sweeps the task table one slot per
//   cycle through a single memory read port; a new item is not taken
//   until the strobe cycle of the last one ends.
// Reset: empty table, time zero, round robin starting at slot 0, idle.
//   Table contents are not cleared; only loaded slots are ever used.
`default_nettype none

module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef
)(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation_i,
  input  wire logic [ArrW-1:0]     arrival_i,
  input  wire logic [BurstW-1:0]   burst_i,
  input  wire logic [PrioW-1:0]    priority_req_i,
  output logic                     strobe_o,
  output logic                     idle_o,
  output logic [SlotOutW-1:0]      running_slot_o,
  output logic                     finished_o,
  output logic [TimeW-1:0]         turnaround_o,
  output logic [TimeW-1:0]         waiting_o,
  output logic                     all_done_o,
  output logic                     table_full_o,
  output logic [TimeW-1:0]         time_now_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each item
  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .strobe_o    (strobe_o)
  );

  // Hold the task table and do the work
  pps_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .arrival_i      (arrival_i),
    .burst_i        (burst_i),
    .priority_req_i (priority_req_i),
    .idle_o         (idle_o),
    .running_slot_o (running_slot_o),
    .finished_o     (finished_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .all_done_o     (all_done_o),
    .table_full_o   (table_full_o),
    .time_now_o     (time_now_o)
  );

endmodule

`default_nettype wire

[sv/pps_ctrl.sv]
// Controller state machine of the preemptive priority scheduler.
// Depends on pps_pkg; drives the datapath pps_dp through cmd_t and sts_t.
`default_nettype none

module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] operation_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o,
  output logic            busy,
  output logic            strobe_o
);

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(operation_i);

  // Sequence the phases of one item
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          unique case (op)
            OP_LOAD:  state_d = S_LOAD;
            OP_TICK:  state_d = S_SCAN;
            OP_CLEAR: state_d = S_CLEAR;
            default:  state_d = S_REPORT;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_REPORT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = sts_i.will_finish ? S_FIN : S_REPORT;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_REPORT;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_REPORT;
      end
      S_REPORT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = (state_q == S_REPORT);

endmodule

`default_nettype wire

[sv/pps_dp.sv]
// Datapath of the preemptive priority scheduler: task table memory,
// round-robin sweep, best-task register, time and counters. Uses pps_pkg.
`default_nettype none

module pps_dp
  import pps_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef
)(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [ArrW-1:0]     arrival_i,
  input  wire logic [BurstW-1:0]   burst_i,
  input  wire logic [PrioW-1:0]    priority_req_i,
  output logic                     idle_o,
  output logic [SlotOutW-1:0]      running_slot_o,
  output logic                     finished_o,
  output logic [TimeW-1:0]         turnaround_o,
  output logic [TimeW-1:0]         waiting_o,
  output logic                     all_done_o,
  output logic                     table_full_o,
  output logic [TimeW-1:0]         time_now_o
);

  localparam int unsigned SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TASK_SLOTS + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TASK_SLOTS - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(TASK_SLOTS);

  // Task table and its registered read port
  entry_t mem_q [TASK_SLOTS];
  entry_t rdata_q;
  logic   mem_we;
  logic [SlotW-1:0] mem_waddr;
  entry_t mem_wdata;

  // Latched operands
  logic [ArrW-1:0]   arr_q;
  logic [BurstW-1:0] burst_q;
  logic [PrioW-1:0]  prio_q;

  // Scheduler state
  logic [CntW-1:0]  loaded_q, loaded_d;
  logic [CntW-1:0]  done_q, done_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [SlotW-1:0] last_q, last_d;

  // Sweep
  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             eval_v_q;
  logic [SlotW-1:0] rd_slot_q;

  // Best ready task found so far
  logic             best_v_q, best_v_d;
  logic [SlotW-1:0] best_slot_q, best_slot_d;
  entry_t           best_q, best_d;

  // Result staging
  logic             idle_q, idle_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             fin_q, fin_d;
  logic             full_q, full_d;
  logic [TimeW-1:0] turn_q, turn_d;
  logic [TimeW-1:0] wait_q, wait_d;

  logic [BurstW-1:0] load_burst;
  logic [BurstW-1:0] rem_next;
  logic              ready;
  logic [SlotW-1:0]  start_ptr;
  logic [TimeW-1:0]  turn_calc;

  assign load_burst = (burst_i == '0) ? BurstW'(1) : burst_i;
  assign rem_next   = best_q.remaining - BurstW'(1);
  assign start_ptr  = (last_q == LastSlot) ? '0 : last_q + SlotW'(1);
  assign turn_calc  = time_q - TimeW'(best_q.arrival);

  // Slot under evaluation is loaded, unfinished and has arrived
  assign ready = eval_v_q
              && (CntW'(rd_slot_q) < loaded_q)
              && (rdata_q.remaining != '0)
              && (TimeW'(rdata_q.arrival) <= time_q);

  assign sts_o.scan_last   = (cnt_q == LastSlot);
  assign sts_o.will_finish = best_v_q && (best_q.remaining == BurstW'(1));

  // Choose the table write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_slot_q;
    mem_wdata = '{arrival: best_q.arrival, burst: best_q.burst,
                  prio: best_q.prio, remaining: rem_next};
    if (cmd_i.load && (loaded_q < FullCnt)) begin
      mem_we    = 1'b1;
      mem_waddr = loaded_q[SlotW-1:0];
      mem_wdata = '{arrival: arr_q, burst: burst_q, prio: prio_q,
                    remaining: burst_q};
    end else if (cmd_i.run && best_v_q) begin
      mem_we = 1'b1;
    end
  end

  // Write and read the table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q   <= mem_q[ptr_q];
    rd_slot_q <= ptr_q;
  end

  // Latch operands on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      arr_q   <= arrival_i;
      burst_q <= load_burst;
      prio_q  <= priority_req_i;
    end
  end

  // Next state of counters, sweep, best task and result
  always_comb begin
    loaded_d    = loaded_q;
    done_d      = done_q;
    time_d      = time_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    best_v_d    = best_v_q;
    best_slot_d = best_slot_q;
    best_d      = best_q;
    idle_d      = idle_q;
    slot_d      = slot_q;
    fin_d       = fin_q;
    full_d      = full_q;
    turn_d      = turn_q;
    wait_d      = wait_q;

    // Arm sweep and clear the result
    if (cmd_i.accept) begin
      ptr_d    = start_ptr;
      cnt_d    = '0;
      best_v_d = 1'b0;
      idle_d   = 1'b0;
      slot_d   = '0;
      fin_d    = 1'b0;
      full_d   = 1'b0;
      turn_d   = '0;
      wait_d   = '0;
    end

    // Advance the sweep one slot
    if (cmd_i.scan_step) begin
      ptr_d = (ptr_q == LastSlot) ? '0 : ptr_q + SlotW'(1);
      cnt_d = cnt_q + SlotW'(1);
    end

    // Keep the first strictly better ready task
    if (ready && (!best_v_q || (rdata_q.prio < best_q.prio))) begin
      best_v_d    = 1'b1;
      best_slot_d = rd_slot_q;
      best_d      = rdata_q;
    end

    // Store a task or refuse it
    if (cmd_i.load) begin
      if (loaded_q < FullCnt) begin
        slot_d   = loaded_q[SlotW-1:0];
        loaded_d = loaded_q + CntW'(1);
      end else begin
        full_d = 1'b1;
      end
    end

    // Run one unit and advance time
    if (cmd_i.run) begin
      time_d = (time_q == '1) ? time_q : time_q + TimeW'(1);
      if (best_v_q) begin
        slot_d           = best_slot_q;
        last_d           = best_slot_q;
        best_d.remaining = rem_next;
        if (rem_next == '0) begin
          fin_d  = 1'b1;
          done_d = done_q + CntW'(1);
        end
      end else begin
        idle_d = 1'b1;
      end
    end

    // Report turnaround and waiting of the finished task
    if (cmd_i.finish) begin
      turn_d = turn_calc;
      wait_d = (turn_calc > TimeW'(best_q.burst))
             ? turn_calc - TimeW'(best_q.burst) : '0;
    end

    // Empty the table
    if (cmd_i.clear) begin
      loaded_d = '0;
      done_d   = '0;
      time_d   = '0;
      last_d   = LastSlot;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      done_q   <= '0;
      time_q   <= '0;
      last_q   <= LastSlot;
      ptr_q    <= '0;
      cnt_q    <= '0;
      eval_v_q <= 1'b0;
      best_v_q <= 1'b0;
      idle_q   <= 1'b0;
      fin_q    <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
      done_q   <= done_d;
      time_q   <= time_d;
      last_q   <= last_d;
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
      eval_v_q <= cmd_i.scan_step;
      best_v_q <= best_v_d;
      idle_q   <= idle_d;
      fin_q    <= fin_d;
      full_q   <= full_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_slot_q <= best_slot_d;
    best_q      <= best_d;
    slot_q      <= slot_d;
    turn_q      <= turn_d;
    wait_q      <= wait_d;
  end

  assign idle_o         = idle_q;
  assign running_slot_o = SlotOutW'(slot_q);
  assign finished_o     = fin_q;
  assign turnaround_o   = turn_q;
  assign waiting_o      = wait_q;
  assign all_done_o     = (loaded_q != '0) && (done_q == loaded_q);
  assign table_full_o   = full_q;
  assign time_now_o     = time_q;

endmodule

`default_nettype wire
